// ===== design/assert_macros.svh =====
// Assertion macros shared by the anchor box decoder modules.
// Each use expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is high.
`define ABD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising edge.
`define ABD_NEVER(label, expr, msg) \
  `ABD_ASSERT(label, !(expr), msg)

`endif

// ===== design/abd_pkg.sv =====
// Shared types, constants and the exponent factor table of the anchor box decoder.
// No dependencies.
package abd_pkg;

  localparam int MAX_NET_DIM = 2048;
  localparam int NUM_LEVELS  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_NET_WIDTH       = 3'd0;
  localparam logic [2:0] REG_NET_HEIGHT      = 3'd1;
  localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_SCALE_X         = 3'd3;
  localparam logic [2:0] REG_SCALE_Y         = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH     = 3'd5;
  localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd6;

  // 0.1 in Q0.16.
  localparam logic [12:0] CENTER_GAIN = 13'd6554;
  localparam logic [19:0] EXP_ONE     = 20'd65536;

  typedef struct packed {
    logic [11:0] net_width;
    logic [11:0] net_height;
    logic [15:0] score_threshold;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        score;
    logic signed [15:0] off_cx;
    logic signed [15:0] off_cy;
    logic [15:0]        off_w;
    logic [15:0]        off_h;
    logic [1:0]         level;
    logic [8:0]         row;
    logic [8:0]         col;
    logic               size_sel;
    logic [17:0]        count;
    logic               last;
  } item_t;

  // exp(0.2 * 2^(b-12)) in Q16 for bit b of a Q4.12 offset; the sign bit holds exp(-1.6).
  function automatic logic [17:0] exp_factor(input logic [3:0] b);
    logic [17:0] f;
    case (b)
      4'd0:    f = 18'd65539;
      4'd1:    f = 18'd65542;
      4'd2:    f = 18'd65549;
      4'd3:    f = 18'd65562;
      4'd4:    f = 18'd65587;
      4'd5:    f = 18'd65638;
      4'd6:    f = 18'd65741;
      4'd7:    f = 18'd65947;
      4'd8:    f = 18'd66360;
      4'd9:    f = 18'd67195;
      4'd10:   f = 18'd68896;
      4'd11:   f = 18'd72428;
      4'd12:   f = 18'd80046;
      4'd13:   f = 18'd97768;
      4'd14:   f = 18'd145853;
      default: f = 18'd13231;
    endcase
    return f;
  endfunction

endpackage

// ===== design/abd_front.sv =====
// Front end: accepts items and tags each with its prior anchor from the grid counters.
// Depends on abd_pkg.
module abd_front import abd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [11:0]        net_width,
  input  logic [11:0]        net_height,
  input  logic [15:0]        face_score,
  input  logic signed [15:0] offset_cx,
  input  logic signed [15:0] offset_cy,
  input  logic signed [15:0] offset_w,
  input  logic signed [15:0] offset_h,
  output item_t              item
);

  logic [1:0]  level_sel;
  logic [8:0]  grid_row;
  logic [8:0]  grid_col;
  logic        size_sel;
  logic [17:0] anchor_count;

  logic [11:0] dim_w, dim_h;
  logic [12:0] cols, rows;
  logic [2:0]  step_log;
  logic        col_end, row_end, level_end, last;

  function automatic logic [11:0] clamp_dim(input logic [11:0] d);
    if (d < 12'd8) return 12'd8;
    if (d > 12'(MAX_NET_DIM)) return 12'(MAX_NET_DIM);
    return d;
  endfunction

  always_comb begin
    dim_w     = clamp_dim(net_width);
    dim_h     = clamp_dim(net_height);
    step_log  = 3'd3 + {1'b0, level_sel};
    cols      = ({1'b0, dim_w} + (13'd1 << step_log) - 13'd1) >> step_log;
    rows      = ({1'b0, dim_h} + (13'd1 << step_log) - 13'd1) >> step_log;
    col_end   = ({4'd0, grid_col} + 13'd1) >= cols;
    row_end   = ({4'd0, grid_row} + 13'd1) >= rows;
    level_end = ({1'b0, level_sel} + 3'd1) >= 3'(NUM_LEVELS);
    last      = size_sel && col_end && row_end && level_end;

    item.score    = face_score;
    item.off_cx   = offset_cx;
    item.off_cy   = offset_cy;
    item.off_w    = offset_w;
    item.off_h    = offset_h;
    item.level    = level_sel;
    item.row      = grid_row;
    item.col      = grid_col;
    item.size_sel = size_sel;
    item.count    = anchor_count;
    item.last     = last;
  end

  // Size, then column, then row, then level; the whole grid wraps back to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sel    <= '0;
      grid_row     <= '0;
      grid_col     <= '0;
      size_sel     <= 1'b0;
      anchor_count <= '0;
    end else if (take) begin
      anchor_count <= last ? 18'd0 : anchor_count + 18'd1;
      if (!size_sel) begin
        size_sel <= 1'b1;
      end else begin
        size_sel <= 1'b0;
        if (!col_end) begin
          grid_col <= grid_col + 9'd1;
        end else begin
          grid_col <= '0;
          if (!row_end) begin
            grid_row <= grid_row + 9'd1;
          end else begin
            grid_row  <= '0;
            level_sel <= level_end ? 2'd0 : level_sel + 2'd1;
          end
        end
      end
    end
  end

endmodule

// ===== design/abd_queue.sv =====
// Short queue of tagged items between the front end and the decoder.
// Depends on abd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module abd_queue import abd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ABD_NEVER(a_push_full, push && full, "item written into a full queue")
  `ABD_NEVER(a_pop_empty, pop && empty, "item taken from an empty queue")
  `ABD_NEVER(a_count_range, count > (QPTR_W+1)'(QUEUE_DEPTH), "queue count out of range")
  `ABD_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + 1'b1, "count missed a write")

endmodule

// ===== design/abd_back.sv =====
// Back end: decodes tagged items one at a time into frame boxes and holds each result.
// Depends on abd_pkg.
module abd_back import abd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        keep,
  output logic        last_anchor,
  output logic [17:0] anchor_number,
  output logic [11:0] box_x,
  output logic [11:0] box_y,
  output logic [11:0] box_width,
  output logic [11:0] box_height,
  output logic [15:0] box_score
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state;
  item_t       cur;
  logic [3:0]  bit_idx;
  logic [19:0] acc_w, acc_h;
  logic signed [29:0] shx, shy;
  logic [27:0] sz_x, sz_y;
  logic signed [29:0] lo_x, lo_y;
  logic signed [46:0] fx, fy;
  logic [43:0] lx, ly;

  logic [37:0] prod_w, prod_h;
  logic [3:0]  sz_log;
  logic [4:0]  ctr_log;
  logic [30:0] ext_w, ext_h;
  logic [27:0] sz_x_next, sz_y_next;
  logic signed [29:0] lo_x_next, lo_y_next;
  logic [11:0] edge_x, edge_y;
  logic [23:0] len_x, len_y;
  logic        keep_next, out_free;

  function automatic logic signed [29:0] low_edge(input logic [8:0] grid_pos,
                                                  input logic [4:0] c_log,
                                                  input logic signed [29:0] sh,
                                                  input logic [3:0] s_log,
                                                  input logic [27:0] sz);
    logic [29:0]        center;
    logic signed [39:0] sh_full;
    logic signed [39:0] shift;
    center  = 30'({grid_pos, 1'b1}) << c_log;
    sh_full = 40'(sh) <<< s_log;
    shift   = sh_full >>> 16;
    return $signed(center) + 30'(shift) - $signed({2'b00, sz >> 1});
  endfunction

  function automatic logic [11:0] frame_edge(input logic signed [46:0] f,
                                             input logic [11:0] frame);
    logic [26:0] e;
    e = f[46:20];
    if (f < 0) return 12'd0;
    if (e > {15'd0, frame}) return frame;
    return e[11:0];
  endfunction

  always_comb begin
    prod_w    = 38'(acc_w) * 38'(exp_factor(bit_idx)) + 38'd32768;
    prod_h    = 38'(acc_h) * 38'(exp_factor(bit_idx)) + 38'd32768;
    sz_log    = 4'd4 + {1'b0, cur.level, 1'b0} + {3'd0, cur.size_sel};
    // The center is (2n+1) * step / 2 in Q.12, so step log plus eleven.
    ctr_log   = 5'd14 + {3'd0, cur.level};
    ext_w     = 31'(acc_w) << sz_log;
    ext_h     = 31'(acc_h) << sz_log;
    sz_x_next = 28'(ext_w >> 4);
    sz_y_next = 28'(ext_h >> 4);
    lo_x_next = low_edge(cur.col, ctr_log, shx, sz_log, sz_x);
    lo_y_next = low_edge(cur.row, ctr_log, shy, sz_log, sz_y);
    edge_x    = frame_edge(fx, cfg.frame_width);
    edge_y    = frame_edge(fy, cfg.frame_height);
    len_x     = lx[43:20];
    len_y     = ly[43:20];
    keep_next = (cur.score > cfg.score_threshold) &&
                (25'(edge_x) + 25'(len_x) <= 25'(cfg.frame_width)) &&
                (25'(edge_y) + 25'(len_y) <= 25'(cfg.frame_height));
    out_free  = !out_valid || !out_stall;
    pop       = (state == ST_IDLE) && !empty;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= head;
        shx     <= 30'(head.off_cx) * $signed({1'b0, CENTER_GAIN});
        shy     <= 30'(head.off_cy) * $signed({1'b0, CENTER_GAIN});
        acc_w   <= EXP_ONE;
        acc_h   <= EXP_ONE;
        bit_idx <= '0;
      end
      ST_EXP: begin
        if (cur.off_w[bit_idx]) acc_w <= prod_w[35:16];
        if (cur.off_h[bit_idx]) acc_h <= prod_h[35:16];
        bit_idx <= bit_idx + 4'd1;
      end
      ST_SIZE: begin
        sz_x <= sz_x_next;
        sz_y <= sz_y_next;
      end
      ST_MUL: begin
        lo_x <= lo_x_next;
        lo_y <= lo_y_next;
      end
      default: begin
        fx <= 47'(lo_x) * $signed({31'd0, cfg.scale_x});
        fy <= 47'(lo_y) * $signed({31'd0, cfg.scale_y});
        lx <= 44'(sz_x) * 44'(cfg.scale_x);
        ly <= 44'(sz_y) * 44'(cfg.scale_y);
      end
    endcase
  end

  // ST_DONE first forms the products, then pushes out the result once the output register is free.
  logic done_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done_ready <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_DONE && done_ready && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (pop) state <= ST_EXP;
        ST_EXP:  if (bit_idx == 4'd15) state <= ST_SIZE;
        ST_SIZE: state <= ST_MUL;
        ST_MUL:  begin
          state      <= ST_DONE;
          done_ready <= 1'b0;
        end
        ST_DONE: begin
          if (!done_ready) begin
            done_ready <= 1'b1;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && done_ready && out_free) begin
      keep          <= keep_next;
      last_anchor   <= cur.last;
      anchor_number <= cur.count;
      box_x         <= edge_x;
      box_y         <= edge_y;
      box_width     <= (len_x > 24'd4095) ? 12'd4095 : len_x[11:0];
      box_height    <= (len_y > 24'd4095) ? 12'd4095 : len_y[11:0];
      box_score     <= cur.score;
    end
  end

endmodule

// ===== design/anchor_box_decode_filter_top.sv =====
// Prior box decoder and filter: top level with the register file, front end, queue and decoder.
// Depends on abd_pkg, abd_front, abd_queue and abd_back.
//
// Each accepted item is one anchor's score and four Q4.12 offsets; one result comes out per item,
// in order. The front end tags items with their prior anchor and fills a four-entry queue, so up
// to four items wait there, beside the one being decoded and the result held at the output,
// before in_stall rises. The decoder works on one item at a time through a load step, the
// sixteen-step exponent iteration (one table factor per offset bit, one shared multiplier per
// axis) and size, edge, scaling and output steps. Results wait in an output register while
// the next item is decoded. Registers are written through cfg_write, cfg_index and cfg_data
// and should change only while no item is in flight.
module anchor_box_decode_filter_top import abd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        face_score,
  input  logic signed [15:0] offset_cx,
  input  logic signed [15:0] offset_cy,
  input  logic signed [15:0] offset_w,
  input  logic signed [15:0] offset_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               keep,
  output logic               last_anchor,
  output logic [17:0]        anchor_number,
  output logic [11:0]        box_x,
  output logic [11:0]        box_y,
  output logic [11:0]        box_width,
  output logic [11:0]        box_height,
  output logic [15:0]        box_score
);

  cfg_t  cfg;
  item_t front_item, head;
  logic  take, full, empty, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.net_width       <= 12'd640;
      cfg.net_height      <= 12'd640;
      cfg.score_threshold <= 16'd32768;
      cfg.scale_x         <= 16'd256;
      cfg.scale_y         <= 16'd256;
      cfg.frame_width     <= 12'd640;
      cfg.frame_height    <= 12'd640;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NET_WIDTH:       cfg.net_width       <= cfg_data[11:0];
        REG_NET_HEIGHT:      cfg.net_height      <= cfg_data[11:0];
        REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data;
        REG_SCALE_X:         cfg.scale_x         <= cfg_data;
        REG_SCALE_Y:         cfg.scale_y         <= cfg_data;
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[11:0];
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign take     = in_valid && !full;

  abd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .net_width  (cfg.net_width),
    .net_height (cfg.net_height),
    .face_score (face_score),
    .offset_cx  (offset_cx),
    .offset_cy  (offset_cy),
    .offset_w   (offset_w),
    .offset_h   (offset_h),
    .item       (front_item)
  );

  abd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  abd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .keep          (keep),
    .last_anchor   (last_anchor),
    .anchor_number (anchor_number),
    .box_x         (box_x),
    .box_y         (box_y),
    .box_width     (box_width),
    .box_height    (box_height),
    .box_score     (box_score)
  );

endmodule

// ===== bench/anchor_box_decode_filter_top_test.sv =====
// Self-checking bench for the prior box decoder and filter: random and directed anchors,
// with the expected boxes worked out here at each input transfer and compared in order.
// Depends on abd_pkg and anchor_box_decode_filter_top.
`timescale 1ns / 100ps

module anchor_box_decode_filter_top_test;
  import abd_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [15:0] score;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
  } anchor_in_t;

  typedef struct packed {
    logic        keep;
    logic        last;
    logic [17:0] number;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] score;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] face_score = '0;
  logic signed [15:0] offset_cx = '0, offset_cy = '0, offset_w = '0, offset_h = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic keep, last_anchor;
  logic [17:0] anchor_number;
  logic [11:0] box_x, box_y, box_width, box_height;
  logic [15:0] box_score;

  anchor_box_decode_filter_top i_dut (.*);

  // Predictor state and register copy.
  longint nw = 640, nh = 640, thresh = 32768, sx = 256, sy = 256, fw = 640, fh = 640;
  int lvl = 0, row = 0, col = 0, half_sel = 0;
  int unsigned anchor_cnt = 0;
  longint exp_factors[16] = '{65539, 65542, 65549, 65562, 65587, 65638, 65741, 65947,
                              66360, 67195, 68896, 72428, 80046, 97768, 145853, 13231};

  anchor_in_t pending_anchors[$];
  box_t expected_boxes[$];
  int errors = 0;
  bit calm = 1'b0;
  int hold_req = 0, hold_served = 0;
  int gap_left = 0, stall_left = 0, hold_left = 0;

  initial forever #6 clk = ~clk;

  function automatic longint clamp_net(longint d);
    return d < 8 ? 8 : (d > MAX_NET_DIM ? MAX_NET_DIM : d);
  endfunction

  function automatic longint exp_fixed(logic [15:0] raw);
    longint acc = 65536;
    for (int b = 0; b < 16; b++)
      if (raw[b]) acc = (acc * exp_factors[b] + 32768) >> 16;
    return acc;
  endfunction

  task automatic decode_axis(input longint pos, step, size, input logic [15:0] oc, os,
                             input longint scale, frame, output longint px, len);
    longint center, shift, sz, lo, f;
    center = (2 * pos + 1) * step * 2048;
    shift = (longint'($signed(oc)) * size * 6554) >>> 16;
    sz = (size * exp_fixed(os)) >> 4;
    lo = center + shift - (sz >> 1);
    f = lo * scale;
    px = f < 0 ? 0 : f >> 20;
    if (px > frame) px = frame;
    len = (sz * scale) >> 20;
  endtask

  task automatic predict_box(input anchor_in_t a);
    longint step, cols, rows, size, bx, by, bw, bh;
    box_t r;
    step = 8 << lvl;
    cols = (clamp_net(nw) + step - 1) >> (3 + lvl);
    rows = (clamp_net(nh) + step - 1) >> (3 + lvl);
    size = 16 << (2 * lvl + half_sel);
    decode_axis(col, step, size, a.cx, a.w, sx, fw, bx, bw);
    decode_axis(row, step, size, a.cy, a.h, sy, fh, by, bh);
    r.keep = a.score > thresh && bx + bw <= fw && by + bh <= fh;
    r.last = half_sel != 0 && col + 1 >= cols && row + 1 >= rows && lvl + 1 >= NUM_LEVELS;
    r.number = anchor_cnt[17:0];
    r.x = bx[11:0];
    r.y = by[11:0];
    r.width = bw > 4095 ? 12'd4095 : bw[11:0];
    r.height = bh > 4095 ? 12'd4095 : bh[11:0];
    r.score = a.score;
    expected_boxes.insert(expected_boxes.size(), r);
    anchor_cnt = (anchor_cnt + 1) & 18'h3FFFF;
    if (half_sel == 0) begin
      half_sel = 1;
    end else begin
      half_sel = 0;
      if (col + 1 < cols) begin
        col++;
      end else begin
        col = 0;
        if (row + 1 < rows) begin
          row++;
        end else begin
          row = 0;
          if (lvl + 1 < NUM_LEVELS) begin
            lvl++;
          end else begin
            lvl = 0;
            anchor_cnt = 0;
          end
        end
      end
    end
  endtask

  task automatic add_anchor(input anchor_in_t a);
    pending_anchors.insert(pending_anchors.size(), a);
  endtask

  // Input driver: predicts on each transfer, then offers the next anchor after a random gap (none while calm is set).
  always @(posedge clk) begin
    anchor_in_t a;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_box({face_score, offset_cx, offset_cy, offset_w, offset_h});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_anchors.size() > 0) begin
          a = pending_anchors.pop_front();
          face_score <= a.score;
          offset_cx <= a.cx;
          offset_cy <= a.cy;
          offset_w <= a.w;
          offset_h <= a.h;
          in_valid <= 1'b1;
          gap_left = calm ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string field, longint e, longint a);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, field, e, a);
  endtask

  // Output monitor: checks each transfer against the oldest expected box and drives out_stall.
  always @(posedge clk) begin
    box_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, anchor_number %0d", $time, anchor_number);
        end else begin
          e = expected_boxes.pop_front();
          if (keep !== e.keep) report("keep", e.keep, keep);
          if (last_anchor !== e.last) report("last_anchor", e.last, last_anchor);
          if (anchor_number !== e.number) report("anchor_number", e.number, anchor_number);
          if (box_x !== e.x) report("box_x", e.x, box_x);
          if (box_y !== e.y) report("box_y", e.y, box_y);
          if (box_width !== e.width) report("box_width", e.width, box_width);
          if (box_height !== e.height) report("box_height", e.height, box_height);
          if (box_score !== e.score) report("box_score", e.score, box_score);
        end
        stall_left = calm ? 0 : $urandom_range(0, 9);
      end
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_NET_WIDTH:       nw = val[11:0];
      REG_NET_HEIGHT:      nh = val[11:0];
      REG_SCORE_THRESHOLD: thresh = val;
      REG_SCALE_X:         sx = val;
      REG_SCALE_Y:         sy = val;
      REG_FRAME_WIDTH:     fw = val[11:0];
      REG_FRAME_HEIGHT:    fh = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [15:0] w, h, th, scx, scy, frw, frh);
    write_reg(REG_NET_WIDTH, w);
    write_reg(REG_NET_HEIGHT, h);
    write_reg(REG_SCORE_THRESHOLD, th);
    write_reg(REG_SCALE_X, scx);
    write_reg(REG_SCALE_Y, scy);
    write_reg(REG_FRAME_WIDTH, frw);
    write_reg(REG_FRAME_HEIGHT, frh);
    write_reg(REG_UNUSED, 16'hFFFF);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly moderate offsets so that boxes land near their anchors, with full-range noise.
  function automatic anchor_in_t random_anchor();
    anchor_in_t a;
    a.score = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      a.cx = 16'($urandom);
      a.cy = 16'($urandom);
      a.w = 16'($urandom);
      a.h = 16'($urandom);
    end else begin
      a.cx = 16'($signed($urandom_range(0, 8192)) - 4096);
      a.cy = 16'($signed($urandom_range(0, 8192)) - 4096);
      a.w = 16'($signed($urandom_range(0, 8192)) - 4096);
      a.h = 16'($signed($urandom_range(0, 8192)) - 4096);
    end
    return a;
  endfunction

  task automatic run_random(int n);
    repeat (n) add_anchor(random_anchor());
  endtask

  task automatic drain();
    while (pending_anchors.size() > 0 || in_valid || expected_boxes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, single offset bits and the threshold boundary at reset settings.
    add_anchor({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    add_anchor({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    add_anchor({16'd32768, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    add_anchor({16'd32769, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    add_anchor({16'd32767, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
    for (int b = 0; b < 16; b++)
      add_anchor({16'hC000, 16'(1 << b), 16'(1 << b), 16'(1 << b), 16'(1 << b)});
    drain();

    // Tiny grid so that frames wrap often; the change lands mid-grid.
    calm = 1'b1;
    set_cfg(16'hF008, 16'd8, 16'd0, 16'd256, 16'd256, 16'd640, 16'd640);
    run_random(150);
    drain();
    calm = 1'b0;
    run_random(150);
    drain();

    // Out-of-range network sizes, extreme scales and a zero-width frame.
    set_cfg(16'd0, 16'd4095, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd4095);
    run_random(150);
    drain();

    // Long receiver hold while the sender keeps offering.
    set_cfg(16'd40, 16'd24, 16'd30000, 16'd512, 16'd384, 16'd1920, 16'd1080);
    run_random(300);
    hold_req++;
    drain();

    set_cfg(16'd2048, 16'd2048, 16'd100, 16'hFFFF, 16'd1, 16'd4095, 16'd1);
    run_random(100);
    drain();

    set_cfg(16'd24, 16'd16, 16'd40000, 16'd300, 16'd200, 16'd400, 16'd300);
    run_random(150);
    drain();
    calm = 1'b1;
    run_random(150);
    drain();
    calm = 1'b0;

    set_cfg(16'd8, 16'd8, 16'd32768, 16'd256, 16'd256, 16'd8, 16'd8);
    run_random(175);
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
